>>> hdl/sfs_pkg.sv
// Shared types and constants for the sprite frame sequencer.
// No dependencies; imported by sfs_ctrl, sfs_dpath, sprite_frame_sequencer, sfs_frame_check and testbench.
package sfs_pkg;

	// default sizes
	localparam int FRAME_BITS_DEF = 8;
	localparam int TIME_BITS_DEF  = 24;

	// fixed port widths
	localparam int COUNT_REG_W = 9;
	localparam int TIME_IN_W   = 24;
	localparam int INDEX_OUT_W = 8;
	localparam int MODE_W      = 3;
	localparam int UV_FRAC     = 16;
	localparam int UV_W        = UV_FRAC + 1;
	localparam int DIV_CNT_W   = $clog2(UV_FRAC);

	// play modes
	localparam logic [MODE_W-1:0] MODE_STOP  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_LOOP  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_RLOOP = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ONCE  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_RONCE = 3'd4;

	// item opcodes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	// register indexes
	localparam logic REG_FRAMES_ACROSS = 1'b0;
	localparam logic REG_FRAMES_DOWN   = 1'b1;

	typedef struct packed {
		logic capture;   // latch input word
		logic apply;     // start load or time accumulate
		logic advance;   // interval compare and frame step
		logic div_init;  // load divider lanes
		logic div_step;  // one quotient bit per lane
		logic out_load;  // move result into output register
	} cmd_t;

	typedef struct packed {
		logic div_last;
	} sts_t;

endpackage

>>> hdl/sfs_ctrl.sv
// Sequencer control FSM for the sprite frame sequencer.
// Depends on sfs_pkg; drives sfs_dpath through cmd_t, reads sts_t.
module sfs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output sfs_pkg::cmd_t cmd,
	input  sfs_pkg::sts_t sts
);
	import sfs_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_APPLY = 3'd1;
	localparam logic [2:0] S_STEP  = 3'd2;
	localparam logic [2:0] S_DINIT = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       in_accept;
	logic       slot_free;

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					cmd.capture = 1'b1;
					state_d     = S_APPLY;
				end
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = S_STEP;
			end
			S_STEP: begin
				cmd.advance = 1'b1;
				state_d     = S_DINIT;
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = S_OUT;
			end
			S_OUT: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	a_load_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result loaded over a word not yet taken");

	a_accept_apply: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q == S_APPLY))
		else $error("accepted word not followed by apply");

	a_valid_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.out_load))
		else $error("out_valid rose without a result load");

endmodule

>>> hdl/sfs_dpath.sv
// Datapath of the sprite frame sequencer: config, animation state, step logic,
// four-lane bit-serial UV divider and output register. Depends on sfs_pkg.
module sfs_dpath #(
	parameter int FRAME_BITS = sfs_pkg::FRAME_BITS_DEF,
	parameter int TIME_BITS  = sfs_pkg::TIME_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic                              cfg_index,
	input  logic [sfs_pkg::COUNT_REG_W-1:0]   cfg_data,
	input  logic                              op,
	input  logic [sfs_pkg::TIME_IN_W-1:0]     delta_time,
	input  logic [sfs_pkg::MODE_W-1:0]        anim_mode,
	input  logic [sfs_pkg::TIME_IN_W-1:0]     step_interval,
	input  logic                              along_x,
	input  sfs_pkg::cmd_t                     cmd,
	output sfs_pkg::sts_t                     sts,
	output logic [sfs_pkg::INDEX_OUT_W-1:0]   column,
	output logic [sfs_pkg::INDEX_OUT_W-1:0]   row,
	output logic [sfs_pkg::MODE_W-1:0]        mode_now,
	output logic [sfs_pkg::UV_W-1:0]          u_left,
	output logic [sfs_pkg::UV_W-1:0]          u_right,
	output logic [sfs_pkg::UV_W-1:0]          v_top,
	output logic [sfs_pkg::UV_W-1:0]          v_bottom,
	output logic                              uv_valid
);
	import sfs_pkg::*;

	localparam int FB = FRAME_BITS;
	localparam int TW = TIME_BITS;
	localparam int CW = FB + 1;
	localparam int RW = (CW > COUNT_REG_W) ? CW : COUNT_REG_W;
	localparam logic [CW-1:0] CNT_MAX = CW'(1) << FB;
	localparam int NLANE = 4;

	// config
	logic [COUNT_REG_W-1:0] across_q, down_q;
	// captured word
	logic              op_q, along_q;
	logic [TW-1:0]     delta_q, interval_in_q;
	logic [MODE_W-1:0] mode_in_q;
	// animation state
	logic [TW:0]       elapsed_q;
	logic [TW-1:0]     interval_q;
	logic [FB-1:0]     col_q, row_q;
	logic [MODE_W-1:0] mode_q;
	logic              axis_q;
	logic              active_q;
	// divider lanes
	logic [CW-1:0]        rem_q  [NLANE];
	logic [UV_FRAC-1:0]   quo_q  [NLANE];
	logic                 full_q [NLANE];
	logic [DIV_CNT_W-1:0] bit_q;
	// output register
	logic [INDEX_OUT_W-1:0] column_q, row_q_o;
	logic [MODE_W-1:0]      mode_now_q;
	logic [UV_W-1:0]        uv_q [NLANE];
	logic                   uv_valid_q;

	logic [CW-1:0]     nx, ny;
	logic              grid;
	logic [MODE_W-1:0] mode_dec;
	logic [TW+1:0]     acc_sum;
	logic [TW+1:0]     diff;
	logic              hit;
	logic [FB-1:0]     idx_sel, idx_nxt;
	logic [CW-1:0]     cnt_sel, inc, dec, last;
	logic              stop_now;
	logic [CW-1:0]     lane_num [NLANE];
	logic [CW-1:0]     lane_cnt [NLANE];

	// effective counts: zero acts as one, clamp to 2^FRAME_BITS
	always_comb begin
		if (across_q == '0) nx = CW'(1);
		else if (RW'(across_q) > RW'(CNT_MAX)) nx = CNT_MAX;
		else nx = CW'(across_q);
		if (down_q == '0) ny = CW'(1);
		else if (RW'(down_q) > RW'(CNT_MAX)) ny = CNT_MAX;
		else ny = CW'(down_q);
	end
	assign grid = (nx != CW'(1)) || (ny != CW'(1));

	assign mode_dec = (mode_in_q > MODE_RONCE) ? MODE_STOP : mode_in_q;
	assign acc_sum  = {1'b0, elapsed_q} + (TW+2)'(delta_q);
	assign diff     = {1'b0, elapsed_q} - {2'b00, interval_q};
	assign hit      = !diff[TW+1] && (diff != '0);

	// one frame step on the chosen axis
	always_comb begin
		idx_sel  = axis_q ? col_q : row_q;
		cnt_sel  = axis_q ? nx : ny;
		inc      = CW'(idx_sel) + CW'(1);
		dec      = CW'(idx_sel) - CW'(1);
		last     = cnt_sel - CW'(1);
		idx_nxt  = idx_sel;
		stop_now = 1'b0;
		case (mode_q)
			MODE_LOOP: begin
				idx_nxt = (inc >= cnt_sel) ? '0 : FB'(inc);
			end
			MODE_ONCE: begin
				if (inc >= cnt_sel) begin
					idx_nxt  = FB'(last);
					stop_now = 1'b1;
				end else begin
					idx_nxt = FB'(inc);
				end
			end
			MODE_RLOOP: begin
				if (idx_sel == '0) idx_nxt = FB'(last);
				else idx_nxt = (dec > last) ? FB'(last) : FB'(dec);
			end
			MODE_RONCE: begin
				if (idx_sel == '0) begin
					idx_nxt  = '0;
					stop_now = 1'b1;
				end else begin
					idx_nxt = (dec > last) ? FB'(last) : FB'(dec);
				end
			end
			default: idx_nxt = idx_sel;
		endcase
	end

	assign lane_num[0] = CW'(col_q);
	assign lane_num[1] = CW'(col_q) + CW'(1);
	assign lane_num[2] = CW'(row_q);
	assign lane_num[3] = CW'(row_q) + CW'(1);
	assign lane_cnt[0] = nx;
	assign lane_cnt[1] = nx;
	assign lane_cnt[2] = ny;
	assign lane_cnt[3] = ny;

	assign sts.div_last = (bit_q == DIV_CNT_W'(UV_FRAC - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			across_q   <= COUNT_REG_W'(1);
			down_q     <= COUNT_REG_W'(1);
			elapsed_q  <= '0;
			interval_q <= '0;
			col_q      <= '0;
			row_q      <= '0;
			mode_q     <= MODE_STOP;
			axis_q     <= 1'b0;
			active_q   <= 1'b0;
			bit_q      <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_FRAMES_ACROSS: across_q <= cfg_data;
					REG_FRAMES_DOWN:   down_q   <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.apply) begin
				active_q <= (op_q == OP_TICK) && grid && (mode_q != MODE_STOP);
				if (op_q == OP_START) begin
					mode_q     <= mode_dec;
					interval_q <= interval_in_q;
					axis_q     <= along_q;
					elapsed_q  <= '0;
					if (mode_dec == MODE_ONCE) begin
						if (along_q) col_q <= '0;
						else row_q <= '0;
					end else if (mode_dec == MODE_RONCE) begin
						if (along_q) col_q <= FB'(nx - CW'(1));
						else row_q <= FB'(ny - CW'(1));
					end
				end else if (grid && (mode_q != MODE_STOP)) begin
					// saturate at all ones
					elapsed_q <= acc_sum[TW+1] ? '1 : acc_sum[TW:0];
				end
			end
			if (cmd.advance && active_q && hit) begin
				elapsed_q <= diff[TW:0];
				if (axis_q) col_q <= idx_nxt;
				else row_q <= idx_nxt;
				if (stop_now) mode_q <= MODE_STOP;
			end
			if (cmd.div_init) bit_q <= '0;
			else if (cmd.div_step) bit_q <= bit_q + DIV_CNT_W'(1);
		end
	end

	// captured word, divider lanes and output register carry no reset
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q          <= op;
			delta_q       <= TW'(delta_time);
			mode_in_q     <= anim_mode;
			interval_in_q <= TW'(step_interval);
			along_q       <= along_x;
		end
		for (int i = 0; i < NLANE; i++) begin
			if (cmd.div_init) begin
				// num >= count: quotient is 65536 or saturates there
				full_q[i] <= (lane_num[i] >= lane_cnt[i]);
				rem_q[i]  <= lane_num[i];
				quo_q[i]  <= '0;
			end else if (cmd.div_step) begin
				if ({rem_q[i], 1'b0} >= {1'b0, lane_cnt[i]}) begin
					rem_q[i] <= CW'({rem_q[i], 1'b0} - {1'b0, lane_cnt[i]});
					quo_q[i] <= {quo_q[i][UV_FRAC-2:0], 1'b1};
				end else begin
					rem_q[i] <= CW'({rem_q[i], 1'b0});
					quo_q[i] <= {quo_q[i][UV_FRAC-2:0], 1'b0};
				end
			end
		end
		if (cmd.out_load) begin
			column_q   <= INDEX_OUT_W'(col_q);
			row_q_o    <= INDEX_OUT_W'(row_q);
			mode_now_q <= mode_q;
			uv_valid_q <= grid;
			for (int i = 0; i < NLANE; i++) begin
				if (!grid) uv_q[i] <= '0;
				else if (full_q[i]) uv_q[i] <= UV_W'(1) << UV_FRAC;
				else uv_q[i] <= {1'b0, quo_q[i]};
			end
		end
	end

	assign column   = column_q;
	assign row      = row_q_o;
	assign mode_now = mode_now_q;
	assign u_left   = uv_q[0];
	assign u_right  = uv_q[1];
	assign v_top    = uv_q[2];
	assign v_bottom = uv_q[3];
	assign uv_valid = uv_valid_q;

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && !full_q[0]) |-> (rem_q[0] < lane_cnt[0]))
		else $error("divider remainder not below count");

	a_stop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.advance && mode_q == MODE_STOP) |=> $stable(col_q) && $stable(row_q))
		else $error("frame stepped while stopped");

endmodule

>>> hdl/sprite_frame_sequencer.sv
// Top level of the sprite frame sequencer: wires the control FSM to the datapath.
// Depends on sfs_pkg, sfs_ctrl and sfs_dpath.
//
// Use: an input word is a tick (op=0, delta_time) or a start (op=1, anim_mode,
// step_interval, along_x). Each accepted word yields exactly one result word with
// the column and row index, the current mode and the UV rectangle of that frame.
// Input: accepted on in_valid && !in_stall. in_stall is high from acceptance
// until the result has been moved into the output register.
// Output: out_valid holds the result until taken (out_valid && !out_stall).
// Config: cfg_valid/cfg_ready write port, index 0 frames_across, 1 frames_down;
// cfg_ready is always high, write only while no item is in flight.
// Sequence from acceptance to out_valid: apply, step, divider load, then the
// four-lane restoring divider (one UV fraction bit per lane per cycle), then
// the output load. A new word is accepted only once the last result has been
// moved into the output register.
// Receiver stall: the finished result waits in the output register; the next
// word is still accepted and is worked off, then waits in the final state until
// the output register frees up.
// Reset: counts return to 1, mode to stop, indices and time to zero, no result.
module sprite_frame_sequencer #(
	parameter int FRAME_BITS = sfs_pkg::FRAME_BITS_DEF,
	parameter int TIME_BITS  = sfs_pkg::TIME_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// config write port
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [sfs_pkg::COUNT_REG_W-1:0] cfg_data,
	// input word
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            op,
	input  logic [sfs_pkg::TIME_IN_W-1:0]   delta_time,
	input  logic [sfs_pkg::MODE_W-1:0]      anim_mode,
	input  logic [sfs_pkg::TIME_IN_W-1:0]   step_interval,
	input  logic                            along_x,
	// result word
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [sfs_pkg::INDEX_OUT_W-1:0] column,
	output logic [sfs_pkg::INDEX_OUT_W-1:0] row,
	output logic [sfs_pkg::MODE_W-1:0]      mode_now,
	output logic [sfs_pkg::UV_W-1:0]        u_left,
	output logic [sfs_pkg::UV_W-1:0]        u_right,
	output logic [sfs_pkg::UV_W-1:0]        v_top,
	output logic [sfs_pkg::UV_W-1:0]        v_bottom,
	output logic                            uv_valid
);
	import sfs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// registers are plain flops, a write always lands
	assign cfg_ready = 1'b1;

	sfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	sfs_dpath #(
		.FRAME_BITS (FRAME_BITS),
		.TIME_BITS  (TIME_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.op            (op),
		.delta_time    (delta_time),
		.anim_mode     (anim_mode),
		.step_interval (step_interval),
		.along_x       (along_x),
		.cmd           (cmd),
		.sts           (sts),
		.column        (column),
		.row           (row),
		.mode_now      (mode_now),
		.u_left        (u_left),
		.u_right       (u_right),
		.v_top         (v_top),
		.v_bottom      (v_bottom),
		.uv_valid      (uv_valid)
	);

endmodule

>>> tb/sfs_frame_check.sv
// Checker for the sprite frame sequencer: tracks config writes, predicts each result word
// from the accepted input words and compares it field by field with the block's output.
// Depends on sfs_pkg for widths, play modes, opcodes and register indexes.
module sfs_frame_check (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [sfs_pkg::COUNT_REG_W-1:0] cfg_data,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic                            op,
	input  logic [sfs_pkg::TIME_IN_W-1:0]   delta_time,
	input  logic [sfs_pkg::MODE_W-1:0]      anim_mode,
	input  logic [sfs_pkg::TIME_IN_W-1:0]   step_interval,
	input  logic                            along_x,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [sfs_pkg::INDEX_OUT_W-1:0] column,
	input  logic [sfs_pkg::INDEX_OUT_W-1:0] row,
	input  logic [sfs_pkg::MODE_W-1:0]      mode_now,
	input  logic [sfs_pkg::UV_W-1:0]        u_left,
	input  logic [sfs_pkg::UV_W-1:0]        u_right,
	input  logic [sfs_pkg::UV_W-1:0]        v_top,
	input  logic [sfs_pkg::UV_W-1:0]        v_bottom,
	input  logic                            uv_valid,
	output int                              fail_count,
	output int                              expect_cnt
);
	import sfs_pkg::*;

	localparam int     MAX_FRAMES  = 1 << FRAME_BITS_DEF;
	localparam longint ELAPSED_MAX = (64'd1 << (TIME_BITS_DEF + 1)) - 1;
	localparam longint UV_ONE      = 64'd1 << UV_FRAC;

	typedef struct packed {
		logic [INDEX_OUT_W-1:0] column;
		logic [INDEX_OUT_W-1:0] row;
		logic [MODE_W-1:0]      mode;
		logic [UV_W-1:0]        u_left;
		logic [UV_W-1:0]        u_right;
		logic [UV_W-1:0]        v_top;
		logic [UV_W-1:0]        v_bottom;
		logic                   uv_valid;
	} frame_rect_t;

	frame_rect_t rect_due_q[$];

	// shadow of the block's registers and animation state
	logic [COUNT_REG_W-1:0]    across_r   = COUNT_REG_W'(1);
	logic [COUNT_REG_W-1:0]    down_r     = COUNT_REG_W'(1);
	logic [TIME_BITS_DEF:0]    elapsed_r  = '0;
	logic [TIME_BITS_DEF-1:0]  interval_r = '0;
	logic [INDEX_OUT_W-1:0]    col_r      = '0;
	logic [INDEX_OUT_W-1:0]    row_r      = '0;
	logic [MODE_W-1:0]         play_r     = MODE_STOP;
	logic                      axis_x_r   = 1'b0;

	initial begin
		fail_count = 0;
		expect_cnt = 0;
	end

	// 0 acts as 1, anything above the index range clamps to the full range
	function automatic int frame_count(input logic [COUNT_REG_W-1:0] cfg_v);
		if (cfg_v == 0)
			return 1;
		if (cfg_v > MAX_FRAMES)
			return MAX_FRAMES;
		return int'(cfg_v);
	endfunction

	function automatic logic [UV_W-1:0] uv_quot(input int num, input int cnt);
		longint q;
		q = (longint'(num) << UV_FRAC) / cnt;
		return (q > UV_ONE) ? UV_ONE[UV_W-1:0] : q[UV_W-1:0];
	endfunction

	task automatic predict_frame(input logic op_i, input logic [TIME_IN_W-1:0] dt,
			input logic [MODE_W-1:0] am, input logic [TIME_IN_W-1:0] si,
			input logic ax, output frame_rect_t r);
		int     nx, ny, idx, cnt, last;
		bit     grid;
		longint acc;
		nx   = frame_count(across_r);
		ny   = frame_count(down_r);
		grid = (nx != 1) || (ny != 1);
		if (op_i == OP_START) begin
			play_r     = (am > MODE_RONCE) ? MODE_STOP : am;
			interval_r = si;
			axis_x_r   = ax;
			elapsed_r  = '0;
			if (play_r == MODE_ONCE) begin
				if (axis_x_r) col_r = '0; else row_r = '0;
			end else if (play_r == MODE_RONCE) begin
				if (axis_x_r) col_r = 8'(nx - 1); else row_r = 8'(ny - 1);
			end
		end else if (grid && play_r != MODE_STOP) begin
			acc = longint'(elapsed_r) + longint'(dt);
			if (acc > ELAPSED_MAX)
				acc = ELAPSED_MAX;
			if (acc > longint'(interval_r)) begin
				acc  = acc - longint'(interval_r);
				idx  = axis_x_r ? int'(col_r) : int'(row_r);
				cnt  = axis_x_r ? nx : ny;
				last = cnt - 1;
				case (play_r)
					MODE_LOOP: begin
						idx = (idx + 1 >= cnt) ? 0 : idx + 1;
					end
					MODE_ONCE: begin
						if (idx + 1 >= cnt) begin
							play_r = MODE_STOP;
							idx    = last;
						end else begin
							idx = idx + 1;
						end
					end
					MODE_RLOOP, MODE_RONCE: begin
						// reverse from 0: wrap in loop, stop in once; clamp if count shrank
						if (idx == 0) begin
							if (play_r == MODE_RONCE) play_r = MODE_STOP;
							else idx = last;
						end else begin
							idx = (idx - 1 > last) ? last : idx - 1;
						end
					end
					default: ;
				endcase
				if (axis_x_r) col_r = 8'(idx); else row_r = 8'(idx);
			end
			elapsed_r = acc[TIME_BITS_DEF:0];
		end
		r.column = col_r;
		r.row    = row_r;
		r.mode   = play_r;
		if (grid) begin
			r.u_left   = uv_quot(int'(col_r), nx);
			r.u_right  = uv_quot(int'(col_r) + 1, nx);
			r.v_top    = uv_quot(int'(row_r), ny);
			r.v_bottom = uv_quot(int'(row_r) + 1, ny);
			r.uv_valid = 1'b1;
		end else begin
			r.u_left   = '0;
			r.u_right  = '0;
			r.v_top    = '0;
			r.v_bottom = '0;
			r.uv_valid = 1'b0;
		end
	endtask

	task automatic check_field(input string name, input logic [UV_W-1:0] want,
			input logic [UV_W-1:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_rect_t want;
		if (!arst_n) begin
			across_r   = COUNT_REG_W'(1);
			down_r     = COUNT_REG_W'(1);
			elapsed_r  = '0;
			interval_r = '0;
			col_r      = '0;
			row_r      = '0;
			play_r     = MODE_STOP;
			axis_x_r   = 1'b0;
			rect_due_q.delete();
			expect_cnt = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_FRAMES_ACROSS) across_r = cfg_data;
				else down_r = cfg_data;
			end
			// compare before predicting: a word accepted now is never the one leaving now
			if (out_valid && !out_stall) begin
				if (rect_due_q.size() == 0) begin
					fail_count++;
					$display("%0t: result word with no prediction waiting", $time);
				end else begin
					want = rect_due_q.pop_front();
					check_field("column", UV_W'(want.column), UV_W'(column));
					check_field("row", UV_W'(want.row), UV_W'(row));
					check_field("mode_now", UV_W'(want.mode), UV_W'(mode_now));
					check_field("u_left", want.u_left, u_left);
					check_field("u_right", want.u_right, u_right);
					check_field("v_top", want.v_top, v_top);
					check_field("v_bottom", want.v_bottom, v_bottom);
					check_field("uv_valid", UV_W'(want.uv_valid), UV_W'(uv_valid));
				end
			end
			if (in_valid && !in_stall) begin
				predict_frame(op, delta_time, anim_mode, step_interval, along_x, want);
				rect_due_q.push_back(want);
			end
			expect_cnt = rect_due_q.size();
		end
	end

endmodule

>>> tb/testbench.sv
// Top of the sprite frame sequencer testbench: clock, reset, config writes and input
// words with random gaps, plus a randomly stalling receiver. Depends on sfs_pkg,
// sprite_frame_sequencer and sfs_frame_check, which predicts and checks every result word.
module testbench;
	import sfs_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_AFTER  = 260;  // words sent before the long receiver hold-off
	localparam int HOLD_CYCLES = 300;
	localparam int N_PHASES    = 10;

	logic                   clk    = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic                   cfg_index = REG_FRAMES_ACROSS;
	logic [COUNT_REG_W-1:0] cfg_data  = '0;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	logic                   op        = OP_TICK;
	logic [TIME_IN_W-1:0]   delta_time    = '0;
	logic [MODE_W-1:0]      anim_mode     = MODE_STOP;
	logic [TIME_IN_W-1:0]   step_interval = '0;
	logic                   along_x   = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [INDEX_OUT_W-1:0] column, row;
	logic [MODE_W-1:0]      mode_now;
	logic [UV_W-1:0]        u_left, u_right, v_top, v_bottom;
	logic                   uv_valid;

	int fail_count;
	int expect_cnt;
	int words_sent = 0;
	int cycle_cnt  = 0;
	bit burst      = 1'b0;  // phase with no sender gaps
	bit hold_done  = 1'b0;

	// random config phases: extremes, out-of-range counts (0 and 511), and shrinking
	// counts right after a full-size phase so indices sit beyond the new count
	int across_tab[N_PHASES] = '{4, 256, 2, 1, 0, 511, 1, 3, 7, 256};
	int down_tab[N_PHASES]   = '{3, 256, 1, 2, 511, 0, 1, 5, 256, 1};
	int len_tab[N_PHASES]    = '{55, 80, 50, 50, 50, 50, 30, 60, 60, 60};

	sprite_frame_sequencer i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .op(op), .delta_time(delta_time),
		.anim_mode(anim_mode), .step_interval(step_interval), .along_x(along_x),
		.out_valid(out_valid), .out_stall(out_stall), .column(column), .row(row),
		.mode_now(mode_now), .u_left(u_left), .u_right(u_right), .v_top(v_top),
		.v_bottom(v_bottom), .uv_valid(uv_valid)
	);

	sfs_frame_check i_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .op(op), .delta_time(delta_time),
		.anim_mode(anim_mode), .step_interval(step_interval), .along_x(along_x),
		.out_valid(out_valid), .out_stall(out_stall), .column(column), .row(row),
		.mode_now(mode_now), .u_left(u_left), .u_right(u_right), .v_top(v_top),
		.v_bottom(v_bottom), .uv_valid(uv_valid),
		.fail_count(fail_count), .expect_cnt(expect_cnt)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Drives one input word from a falling edge and returns at the falling edge after
	// it was taken. in_valid is left high so a following word goes out without a bubble.
	task automatic offer(input logic op_i, input logic [TIME_IN_W-1:0] dt,
			input logic [MODE_W-1:0] am, input logic [TIME_IN_W-1:0] si,
			input logic ax);
		int gap;
		gap = burst ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		op            = op_i;
		delta_time    = dt;
		anim_mode     = am;
		step_interval = si;
		along_x       = ax;
		in_valid      = 1'b1;
		do @(posedge clk); while (in_stall);
		words_sent++;
		@(negedge clk);
	endtask

	// random word: mostly ticks, starts with mostly legal modes, intervals around the
	// delta range so frames step often, and now and then full-width values
	task automatic offer_random(input bit tick_only);
		logic                 op_i, ax;
		logic [MODE_W-1:0]    am;
		logic [TIME_IN_W-1:0] dt, si;
		int                   r;
		op_i = (!tick_only && $urandom_range(0, 7) == 0) ? OP_START : OP_TICK;
		r = $urandom_range(0, 15);
		if (r < 12) am = MODE_W'($urandom_range(MODE_LOOP, MODE_RONCE));
		else if (r < 14) am = MODE_STOP;
		else am = MODE_W'($urandom_range(5, 7));
		r = $urandom_range(0, 9);
		if (r < 4) si = TIME_IN_W'($urandom_range(0, 24'h00FFFF));
		else if (r < 7) si = TIME_IN_W'($urandom_range(0, 24'h03FFFF));
		else if (r < 8) si = '0;
		else si = TIME_IN_W'($urandom());
		r = $urandom_range(0, 9);
		if (r < 5) dt = TIME_IN_W'($urandom_range(0, 24'h03FFFF));
		else if (r < 7) dt = TIME_IN_W'($urandom());
		else if (r < 8) dt = '0;
		else dt = '1;
		ax = 1'($urandom_range(0, 1));
		offer(op_i, dt, am, si, ax);
	endtask

	task automatic write_reg(input logic idx, input logic [COUNT_REG_W-1:0] val);
		cfg_index = idx;
		cfg_data  = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// wait for every predicted word, then let the pipeline run dry
	task automatic settle();
		in_valid = 1'b0;
		while (expect_cnt != 0) @(negedge clk);
		repeat (25) @(negedge clk);
	endtask

	// receiver: random stall runs, quiet stretches, and one long hold-off so the
	// block backs up and holds in_stall while the sender keeps offering
	initial begin
		int run_left;
		bit stall_now;
		int r;
		run_left  = 0;
		stall_now = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && words_sent >= HOLD_AFTER) begin
				hold_done = 1'b1;
				out_stall = 1'b1;
				for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clk);
				run_left = 0;
			end
			if (run_left == 0) begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					stall_now = 1'b0;
					run_left  = $urandom_range(1, 6);
				end else if (r < 80) begin
					stall_now = 1'b1;
					run_left  = $urandom_range(1, 3);
				end else if (r < 92) begin
					stall_now = 1'b0;
					run_left  = $urandom_range(30, 120);
				end else if (r < 97) begin
					stall_now = 1'b1;
					run_left  = $urandom_range(4, 12);
				end else begin
					stall_now = 1'b1;
					run_left  = $urandom_range(20, 80);
				end
			end
			out_stall = stall_now;
			run_left--;
		end
	end

	// watchdog
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("sprite_frame_sequencer test failed");
		$finish;
	end

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset grid is 1x1: stopped tick, then a start that cannot step anything
		offer(OP_TICK, '1, MODE_STOP, '0, 1'b0);
		offer(OP_START, '0, MODE_LOOP, '0, 1'b1);
		offer(OP_TICK, '1, MODE_STOP, '1, 1'b1);
		settle();

		write_reg(REG_FRAMES_ACROSS, 9'd4);
		write_reg(REG_FRAMES_DOWN, 9'd3);
		// undefined mode lands on stop, and a stopped tick adds nothing
		offer(OP_START, '0, 3'd7, 24'h001234, 1'b1);
		offer(OP_TICK, 24'h020000, MODE_STOP, '0, 1'b0);
		// loop along x: equal time does not step, one more unit does, then wrap
		offer(OP_START, '0, MODE_LOOP, 24'h010000, 1'b1);
		offer(OP_TICK, 24'h010000, MODE_STOP, '0, 1'b0);
		offer(OP_TICK, 24'h000001, MODE_STOP, '0, 1'b0);
		repeat (3) offer(OP_TICK, 24'h030000, MODE_STOP, '0, 1'b0);
		// reverse loop along y from row 0 wraps to the last row
		offer(OP_START, '0, MODE_RLOOP, '0, 1'b0);
		repeat (2) offer(OP_TICK, 24'h000001, MODE_STOP, '0, 1'b1);
		// once along x runs to the last column and stops
		offer(OP_START, '0, MODE_ONCE, '0, 1'b1);
		repeat (4) offer(OP_TICK, 24'h000001, MODE_STOP, '0, 1'b0);
		// reverse once along y starts on the last row and stops at 0
		offer(OP_START, '0, MODE_RONCE, '0, 1'b0);
		repeat (3) offer(OP_TICK, 24'h000001, MODE_STOP, '0, 1'b1);
		// zero interval with full-scale deltas drives elapsed into saturation
		offer(OP_START, '0, MODE_LOOP, '0, 1'b1);
		repeat (3) offer(OP_TICK, '1, MODE_STOP, '0, 1'b0);
		settle();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			write_reg(REG_FRAMES_ACROSS, across_tab[ph][COUNT_REG_W-1:0]);
			write_reg(REG_FRAMES_DOWN, down_tab[ph][COUNT_REG_W-1:0]);
			burst = (ph % 3 == 2);
			// first words of a phase are ticks so indices left from a bigger grid get stepped
			for (int k = 0; k < len_tab[ph]; k++)
				offer_random(k < 4);
			settle();
		end

		if (fail_count == 0)
			$display("sprite_frame_sequencer test passed");
		else
			$display("sprite_frame_sequencer test failed");
		$finish;
	end

endmodule

>>> sim.f
hdl/sfs_pkg.sv
hdl/sfs_ctrl.sv
hdl/sfs_dpath.sv
hdl/sprite_frame_sequencer.sv
tb/sfs_frame_check.sv
tb/testbench.sv
